### src/tms_pkg.sv
// tms_pkg: shared types and constants of the temperature monitor smoother
// holds field widths, transfer payload structs, function/register/alert codes, reset values
// no dependencies
`timescale 1ns / 1ps

package tms_pkg;

  // field widths
  localparam int SAMPLE_W   = 12;
  localparam int TIME_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int ALERT_W    = 2;
  localparam int WINDOW_DEF = 8;

  // item function codes
  localparam logic FUNC_INIT   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  // alert levels
  localparam logic [ALERT_W-1:0] ALERT_OK   = 2'd0;
  localparam logic [ALERT_W-1:0] ALERT_WARN = 2'd1;
  localparam logic [ALERT_W-1:0] ALERT_CRIT = 2'd2;

  // register reset values
  localparam logic signed [SAMPLE_W-1:0] WARN_RESET     = 12'sd880;
  localparam logic signed [SAMPLE_W-1:0] CRIT_RESET     = 12'sd1040;
  localparam logic        [CFG_W-1:0]    INTERVAL_RESET = 16'd900;

  typedef struct packed {
    logic                       func;
    logic [TIME_W-1:0]          now_ms;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] current;
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic [ALERT_W-1:0]         alert;
    logic [TIME_W-1:0]          uptime_ms;
    logic                       sampled;
  } out_item_t;

endpackage

### src/tms_ring.sv
// tms_ring: sample ring buffer, one write port and one registered read port
// depends on tms_pkg for the sample width and the default depth
`timescale 1ns / 1ps

module tms_ring #(
  parameter int DEPTH  = tms_pkg::WINDOW_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [tms_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [tms_pkg::SAMPLE_W-1:0]  rd_data
);

  logic [tms_pkg::SAMPLE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/tms_alu.sv
// tms_alu: shared adder/subtractor used for accumulation, magnitude, division and sign fix-up
// no dependencies
`timescale 1ns / 1ps

module tms_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum
);

  // a + b, or a - b in two's complement when sub is set
  assign sum = a + (b ^ {W{sub}}) + W'(sub);

endmodule

### src/temperature_monitor_smoother.sv
// temperature_monitor_smoother: moving average, min/max tracking and threshold alert
// depends on tms_pkg, tms_ring and tms_alu
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries init items (func 0) and
//   update items (func 1). A transfer happens on a rising edge with valid high
//   and stall low. Init items give no result; update items give one result on
//   the output channel (out_valid, out_stall, out_data).
//   Configuration (cfg_we, cfg_index, cfg_data) writes warn/crit thresholds and
//   the minimum sample interval; write only while the block is idle.
// Timing:
//   The block takes one item at a time; in_stall is high while it works.
//   Init: the sweep writes the first sample into every ring memory entry.
//   Throttled update: result register loaded after the interval check, with no ring sum.
//   Accepted update: result register loaded after one ring read per cycle into the
//   shared adder, then a restoring divide by the fill count at one quotient bit per
//   cycle on that same adder. The next item is taken in the cycle after the load.
// Reset and stall:
//   rst (synchronous) clears the sequencer and monitor state and loads the register
//   reset values; the ring memory, the held item, acc, q, rem, neg and out_data are
//   not cleared. A stalled result stays in the output register; the next item may
//   be taken meanwhile, and its result waits until the held one is transferred.
`timescale 1ns / 1ps

module temperature_monitor_smoother #(
  parameter int WINDOW = tms_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tms_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tms_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [tms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tms_pkg::CFG_W-1:0]       cfg_data
);

  localparam int SW     = tms_pkg::SAMPLE_W;
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SW + $clog2(WINDOW);
  localparam int AW     = SUM_W + 1;
  localparam int BC_W   = $clog2(SUM_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_CHECK, S_ACC, S_ABS, S_DIV, S_SIGN, S_ALERT, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic signed [SW-1:0]             warn_thr;
  logic signed [SW-1:0]             crit_thr;
  logic [tms_pkg::CFG_W-1:0]        min_interval;

  // monitor state
  tms_pkg::in_item_t                item;
  logic [PTR_W-1:0]                 wp;
  logic [CNT_W-1:0]                 fill;
  logic signed [SW-1:0]             low_mark;
  logic signed [SW-1:0]             high_mark;
  logic signed [SW-1:0]             avg_reg;
  logic [tms_pkg::ALERT_W-1:0]      alert_reg;
  logic [tms_pkg::TIME_W-1:0]       last_time;
  logic [tms_pkg::TIME_W-1:0]       start_time;
  logic                             first_pending;

  // sequencer working registers
  logic [CNT_W-1:0]                 idx;
  logic                             rd_pend;
  logic signed [SUM_W-1:0]          acc;
  logic                             neg;
  logic [SUM_W-1:0]                 q;
  logic [CNT_W-1:0]                 rem;
  logic [BC_W-1:0]                  bitcnt;
  logic                             sampled_r;

  // ring and alu connections
  logic                             ring_we;
  logic [PTR_W-1:0]                 ring_waddr;
  logic [SW-1:0]                    ring_wdata;
  logic                             ring_re;
  logic [PTR_W-1:0]                 ring_raddr;
  logic [SW-1:0]                    ring_rdata;
  logic [AW-1:0]                    alu_a;
  logic [AW-1:0]                    alu_b;
  logic                             alu_sub;
  logic [AW-1:0]                    alu_sum;

  // throttle and helper values
  logic [tms_pkg::TIME_W-1:0]       last_eff;
  logic [tms_pkg::TIME_W-1:0]       elapsed;
  logic                             throttled;
  logic [PTR_W-1:0]                 wp_prev;
  logic [PTR_W-1:0]                 wp_next;
  logic [CNT_W:0]                   rem_sh;
  logic [SW-1:0]                    current_sel;

  tms_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  tms_alu #(
    .W (AW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  assign in_stall = rst || (state != S_IDLE);

  // interval check against the last accepted sample
  assign last_eff  = first_pending ? item.now_ms : last_time;
  assign elapsed   = item.now_ms - last_eff;
  assign throttled = elapsed < tms_pkg::TIME_W'(min_interval);

  // ring pointer neighbors
  assign wp_prev = (wp == '0) ? PTR_W'(WINDOW - 1) : wp - 1'b1;
  assign wp_next = (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + 1'b1;

  // divider shift-in of the next dividend bit
  assign rem_sh = {rem, q[SUM_W-1]};

  assign current_sel = sampled_r ? item.sample : ring_rdata;

  // ring port control
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = wp;
    ring_wdata = item.sample;
    ring_re    = 1'b0;
    ring_raddr = wp_prev;
    unique case (state)
      S_INIT: begin
        ring_we    = 1'b1;
        ring_waddr = idx[PTR_W-1:0];
      end
      S_CHECK: begin
        ring_we = !throttled;
        ring_re = 1'b1;
      end
      S_ACC: begin
        ring_re    = (idx != fill);
        ring_raddr = idx[PTR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // shared adder operand selection
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_ACC: begin
        alu_a = AW'(acc);
        alu_b = AW'($signed(ring_rdata));
      end
      S_ABS: begin
        alu_b   = AW'(acc);
        alu_sub = acc[SUM_W-1];
      end
      S_DIV: begin
        alu_a   = AW'(rem_sh);
        alu_b   = AW'(fill);
        alu_sub = 1'b1;
      end
      S_SIGN: begin
        alu_b   = AW'(q);
        alu_sub = neg;
      end
      default: begin
      end
    endcase
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      warn_thr      <= tms_pkg::WARN_RESET;
      crit_thr      <= tms_pkg::CRIT_RESET;
      min_interval  <= tms_pkg::INTERVAL_RESET;
      wp            <= '0;
      fill          <= '0;
      low_mark      <= '0;
      high_mark     <= '0;
      avg_reg       <= '0;
      alert_reg     <= tms_pkg::ALERT_OK;
      last_time     <= '0;
      start_time    <= '0;
      first_pending <= 1'b1;
      idx           <= '0;
      rd_pend       <= 1'b0;
      bitcnt        <= '0;
      sampled_r     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          tms_pkg::CFG_WARN:     warn_thr     <= cfg_data[SW-1:0];
          tms_pkg::CFG_CRIT:     crit_thr     <= cfg_data[SW-1:0];
          tms_pkg::CFG_INTERVAL: min_interval <= cfg_data;
          default: begin
          end
        endcase
      end

      // result transfer frees the output register unless a new result loads
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            idx  <= '0;
            if (in_data.func == tms_pkg::FUNC_INIT) begin
              start_time    <= in_data.now_ms;
              last_time     <= '0;
              first_pending <= 1'b1;
              wp            <= '0;
              fill          <= CNT_W'(1);
              low_mark      <= in_data.sample;
              high_mark     <= in_data.sample;
              avg_reg       <= in_data.sample;
              alert_reg     <= tms_pkg::ALERT_OK;
              state         <= S_INIT;
            end else begin
              state <= S_CHECK;
            end
          end
        end

        // fill every ring entry with the first sample
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx[PTR_W-1:0] == PTR_W'(WINDOW - 1)) begin
            state <= S_IDLE;
          end
        end

        S_CHECK: begin
          first_pending <= 1'b0;
          if (throttled) begin
            last_time <= last_eff;
            sampled_r <= 1'b0;
            state     <= S_OUT;
          end else begin
            last_time <= item.now_ms;
            wp        <= wp_next;
            if (fill != CNT_W'(WINDOW)) begin
              fill <= fill + 1'b1;
            end
            if (item.sample < low_mark) begin
              low_mark <= item.sample;
            end
            if (item.sample > high_mark) begin
              high_mark <= item.sample;
            end
            acc       <= '0;
            rd_pend   <= 1'b0;
            sampled_r <= 1'b1;
            state     <= S_ACC;
          end
        end

        // one ring read per cycle, summed in the cycle after its read
        S_ACC: begin
          if (idx != fill) begin
            idx     <= idx + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            acc <= alu_sum[SUM_W-1:0];
          end
          if (idx == fill && !rd_pend) begin
            state <= S_ABS;
          end
        end

        // magnitude of the sum as dividend
        S_ABS: begin
          neg    <= acc[SUM_W-1];
          q      <= alu_sum[SUM_W-1:0];
          rem    <= '0;
          bitcnt <= BC_W'(SUM_W);
          state  <= S_DIV;
        end

        // restoring divide by the fill count, one bit per cycle
        S_DIV: begin
          if (!alu_sum[AW-1]) begin
            rem <= alu_sum[CNT_W-1:0];
            q   <= {q[SUM_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[CNT_W-1:0];
            q   <= {q[SUM_W-2:0], 1'b0};
          end
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == BC_W'(1)) begin
            state <= S_SIGN;
          end
        end

        // restore the sign, truncation toward zero
        S_SIGN: begin
          avg_reg <= alu_sum[SW-1:0];
          state   <= S_ALERT;
        end

        S_ALERT: begin
          priority if (avg_reg > crit_thr) begin
            alert_reg <= tms_pkg::ALERT_CRIT;
          end else if (avg_reg > warn_thr) begin
            alert_reg <= tms_pkg::ALERT_WARN;
          end else begin
            alert_reg <= tms_pkg::ALERT_OK;
          end
          state <= S_OUT;
        end

        // load the result once the output register is free
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_data.current   <= current_sel;
            out_data.average   <= avg_reg;
            out_data.minimum   <= low_mark;
            out_data.maximum   <= high_mark;
            out_data.alert     <= alert_reg;
            out_data.uptime_ms <= item.now_ms - start_time;
            out_data.sampled   <= sampled_r;
            state              <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the window size
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW))
    else $error("fill count above window size");

  // divider remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < fill)
    else $error("divider remainder not below fill count");

  // a new result only comes out of the result load state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the load state");

  // a fresh average lies between minimum and maximum
  a_avg_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sampled |->
      out_data.minimum <= out_data.average && out_data.average <= out_data.maximum)
    else $error("average outside min/max bounds");
`endif

endmodule
